>>> design/fir51_pkg.sv
`default_nettype none
package fir51_pkg;

    localparam int TAPS        = 51;
    localparam int CNT_W       = 6;
    localparam int COEF_W      = 15;
    localparam int OUT_W       = 14;
    localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;
    localparam int SCALE_SHIFT = 14;

    localparam logic signed [COEF_W-1:0] COEF [TAPS] = '{
        -15'sd11,   15'sd10,   15'sd9,   -15'sd5,    15'sd1,    15'sd0,
        -15'sd19,   15'sd6,    15'sd48,  -15'sd12,  -15'sd92,   15'sd17,
         15'sd155, -15'sd20,  -15'sd243,  15'sd22,   15'sd370, -15'sd24,
        -15'sd559,  15'sd24,   15'sd881, -15'sd24,  -15'sd1584, 15'sd24,
         15'sd4932, 15'sd8578, 15'sd4932, 15'sd24,  -15'sd1584, -15'sd24,
         15'sd881,  15'sd24,  -15'sd559, -15'sd24,   15'sd370,  15'sd22,
        -15'sd243, -15'sd20,   15'sd155,  15'sd17,  -15'sd92,  -15'sd12,
         15'sd48,   15'sd6,   -15'sd19,   15'sd0,    15'sd1,   -15'sd5,
         15'sd9,    15'sd10,  -15'sd11
    };

    typedef struct packed {
        logic load;
        logic rotate;
    } cell_ctrl_t;

    typedef struct packed {
        logic clear;
        logic acc_en;
    } mac_ctrl_t;

endpackage
`default_nettype wire

>>> design/fir51_cell.sv
`default_nettype none
module fir51_cell #(
    parameter int SAMPLE_BITS = 12
) (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire fir51_pkg::cell_ctrl_t  ctrl,
    input  wire  [SAMPLE_BITS-1:0]      load_in,
    input  wire  [SAMPLE_BITS-1:0]      rotate_in,
    output logic [SAMPLE_BITS-1:0]      q
);
    import fir51_pkg::*;

    logic [SAMPLE_BITS-1:0] data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_reg <= '0;
        end else if (ctrl.load) begin
            data_reg <= load_in;
        end else if (ctrl.rotate) begin
            data_reg <= rotate_in;
        end
    end

    assign q = data_reg;

endmodule
`default_nettype wire

>>> design/fir51_mac.sv
`default_nettype none
module fir51_mac #(
    parameter int SAMPLE_BITS = 12
) (
    input  wire                                     aclk,
    input  wire fir51_pkg::mac_ctrl_t               ctrl,
    input  wire  [SAMPLE_BITS-1:0]                  sample,
    input  wire  signed [fir51_pkg::COEF_W-1:0]     coef,
    output logic signed [fir51_pkg::OUT_W-1:0]      result
);
    import fir51_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + 1 + COEF_W;
    localparam int ACC_W  = PROD_W + CNT_W;

    localparam logic signed [ACC_W-1:0] BIAS    = ACC_W'((1 << SCALE_SHIFT) - 1);
    localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] OUT_MIN = -ACC_W'(1 << (OUT_W - 1));

    logic signed [PROD_W-1:0] product;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  biased;
    logic signed [ACC_W-1:0]  quot;

    assign product  = PROD_W'($signed({1'b0, sample})) * PROD_W'(coef);
    assign acc_next = acc_reg + ACC_W'(product);

    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            acc_reg <= '0;
        end else if (ctrl.acc_en) begin
            acc_reg <= acc_next;
        end
    end

    // truncate toward zero: bias negative sums before the arithmetic shift
    assign biased = acc_reg[ACC_W-1] ? acc_reg + BIAS : acc_reg;
    assign quot   = biased >>> SCALE_SHIFT;

    always_comb begin
        if (quot > OUT_MAX) begin
            result = OUT_MAX[OUT_W-1:0];
        end else if (quot < OUT_MIN) begin
            result = OUT_MIN[OUT_W-1:0];
        end else begin
            result = quot[OUT_W-1:0];
        end
    end

endmodule
`default_nettype wire

>>> design/fir_lowpass_51_tap_core.sv
`default_nettype none
// 51-tap linear-phase low-pass FIR for unsigned ADC samples. Each accepted
// request shifts its sample into a ring of 51 history cells (all zero after
// reset), then the ring rotates once through a single shared multiply-accumulate,
// one tap per cycle, and the sum is divided by 16384 with truncation toward zero
// and saturated to a signed 14-bit result. After the rotation the scaled result
// is written to the output register once that register is free, and the core
// returns to idle; a stalled output delays this. No new request is taken before
// then, but a new request is taken while the previous result still waits on
// the output register. s_tdata carries sample in its low SAMPLE_BITS; m_tdata
// carries filtered (two's complement) in bits 13:0, zero-padded above.
module fir_lowpass_51_tap_core #(
    parameter int SAMPLE_BITS = 12
) (
    input  wire                                     aclk,
    input  wire                                     aresetn,
    input  wire                                     s_tvalid,
    output logic                                    s_tready,
    input  wire  [((SAMPLE_BITS + 7) / 8) * 8-1:0]  s_tdata,   // sample
    output logic                                    m_tvalid,
    input  wire                                     m_tready,
    output logic [fir51_pkg::OUT_BYTES_W-1:0]       m_tdata    // filtered
);
    import fir51_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_FINISH
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    logic [CNT_W-1:0]         cnt_reg;
    logic [CNT_W-1:0]         cnt_next;
    logic                     m_tvalid_reg;
    logic                     m_tvalid_next;
    logic [OUT_W-1:0]         filt_reg;
    logic [OUT_W-1:0]         filt_next;

    logic                     s_accept;
    cell_ctrl_t               cell_ctrl;
    mac_ctrl_t                mac_ctrl;
    logic [SAMPLE_BITS-1:0]   cell_q [TAPS];
    logic signed [OUT_W-1:0]  mac_result;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    assign cell_ctrl.load   = s_accept;
    assign cell_ctrl.rotate = (state_reg == ST_CALC);
    assign mac_ctrl.clear   = s_accept;
    assign mac_ctrl.acc_en  = (state_reg == ST_CALC);

    for (genvar i = 0; i < TAPS; i++) begin : g_cell
        logic [SAMPLE_BITS-1:0] load_in;
        logic [SAMPLE_BITS-1:0] rotate_in;

        if (i == 0) begin : g_head
            assign load_in = s_tdata[SAMPLE_BITS-1:0];
        end else begin : g_body
            assign load_in = cell_q[i-1];
        end

        if (i == TAPS - 1) begin : g_tail
            assign rotate_in = cell_q[0];
        end else begin : g_link
            assign rotate_in = cell_q[i+1];
        end

        fir51_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (cell_ctrl),
            .load_in   (load_in),
            .rotate_in (rotate_in),
            .q         (cell_q[i])
        );
    end

    fir51_mac #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .aclk   (aclk),
        .ctrl   (mac_ctrl),
        .sample (cell_q[0]),
        .coef   (COEF[cnt_reg]),
        .result (mac_result)
    );

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        filt_next     = filt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    cnt_next   = '0;
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(TAPS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hold the result until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    filt_next     = mac_result;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        filt_reg <= filt_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_BYTES_W - OUT_W){1'b0}}, filt_reg};

endmodule
`default_nettype wire
